// ===== design/wcb_pkg.sv =====
// shared types, widths and codes for the write coalescing buffer
package wcb_pkg;

  localparam int WCB_SLOTS   = 16;
  localparam int RECIP_SHIFT = 24;

  localparam int ID_W       = 16;
  localparam int WORD_W     = 64;
  localparam int THR_W      = 5;
  localparam int LEVEL_W    = 5;
  localparam int SLOT_OUT_W = 4;
  localparam int REQ_W      = 2;
  localparam int KIND_W     = 3;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [THR_W-1:0]  THR_RESET      = 5'd4;
  localparam logic [CFG_AW-1:0] ADDR_FLUSH_THR = 2'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAVE  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_FLUSH = 2'd2
  } wcb_req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAVE_ACK    = 3'd0,
    KIND_LOAD_HIT    = 3'd1,
    KIND_LOAD_MISS   = 3'd2,
    KIND_FLASH_WRITE = 3'd3,
    KIND_FLUSH_EMPTY = 3'd4
  } wcb_kind_t;

  typedef struct packed {
    logic      load_item;
    logic      step_mul;
    logic      step_mod;
    logic      step_fix;
    logic      do_save;
    logic      rd_idx;
    logic      idx_clear;
    logic      idx_inc;
    logic      emit;
    wcb_kind_t emit_kind;
    logic      emit_last;
  } wcb_cmd_t;

  typedef struct packed {
    wcb_req_t req;
    logic     force_wr;
    logic     slot_dirty;
    logic     idx_dirty;
    logic     cnt_zero;
    logic     cnt_one;
    logic     thr_hit;
    logic     out_free;
  } wcb_sts_t;

endpackage

// ===== design/wcb_intf.sv =====
// request and result channel interfaces
interface wcb_req_if import wcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ID_W-1:0]   rec_id;
  logic [WORD_W-1:0] record_word;
  logic              force_write;

  modport source (output valid, req_type, rec_id, record_word, force_write,
                  input ready);
  modport sink (input valid, req_type, rec_id, record_word, force_write,
                output ready);
endinterface

interface wcb_rsp_if import wcb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     result_kind;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [ID_W-1:0]       miss_id;
  logic [WORD_W-1:0]     data_word;
  logic [LEVEL_W-1:0]    dirty_level;
  logic                  last_result;

  modport source (output valid, result_kind, slot_index, miss_id, data_word,
                  dirty_level, last_result, input ready);
  modport sink (input valid, result_kind, slot_index, miss_id, data_word,
                dirty_level, last_result, output ready);
endinterface

// ===== design/wcb_ram.sv =====
// generic single write port ram with registered read
module wcb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/wcb_ctrl.sv =====
// sequencing fsm: slot mapping, save/load dispatch and flush scan
module wcb_ctrl import wcb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wcb_sts_t sts,
  output wcb_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_FIX,
    ST_EXEC,
    ST_ACK,
    ST_LOAD_OUT,
    ST_EMPTY,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   flush_go;

  assign in_ready = (state_r == ST_IDLE);
  assign flush_go = sts.force_wr || sts.thr_hit;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = ST_MOD;
      end
      ST_MOD: begin
        cmd.step_mod = 1'b1;
        state_nxt    = ST_FIX;
      end
      ST_FIX: begin
        cmd.step_fix = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (sts.req)
          REQ_SAVE: begin
            cmd.do_save = 1'b1;
            state_nxt   = ST_ACK;
          end
          REQ_LOAD: begin
            state_nxt = ST_LOAD_OUT;
          end
          REQ_FLUSH: begin
            if (sts.cnt_zero) begin
              state_nxt = ST_EMPTY;
            end else begin
              cmd.idx_clear = 1'b1;
              state_nxt     = ST_SCAN;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_SAVE_ACK;
          cmd.emit_last = !flush_go;
          if (flush_go) begin
            cmd.idx_clear = 1'b1;
            state_nxt     = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOAD_OUT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sts.slot_dirty ? KIND_LOAD_HIT : KIND_LOAD_MISS;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FLUSH_EMPTY;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.rd_idx = 1'b1;
        if (sts.idx_dirty) begin
          state_nxt = ST_WRITE;
        end else if (sts.cnt_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.rd_idx = 1'b1;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FLASH_WRITE;
          cmd.emit_last = sts.cnt_one;
          cmd.idx_inc   = 1'b1;
          state_nxt     = sts.cnt_one ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/wcb_datapath.sv =====
// item registers, slot mapping, dirty tracking, slot ram and result register
module wcb_datapath import wcb_pkg::*; #(
  parameter int SLOTS = WCB_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wcb_cmd_t              cmd,
  output wcb_sts_t              sts,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [ID_W-1:0]       in_rec_id,
  input  logic [WORD_W-1:0]     in_record_word,
  input  logic                  in_force_write,
  input  logic                  thr_we,
  input  logic [THR_W-1:0]      thr_wdata,
  output logic [THR_W-1:0]      thr_value,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  output logic [ID_W-1:0]       out_miss_id,
  output logic [WORD_W-1:0]     out_data_word,
  output logic [LEVEL_W-1:0]    out_dirty_level,
  output logic                  out_last_result
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int REM_W  = $clog2(2 * SLOTS);
  localparam int PROD_W = ID_W + RECIP_SHIFT;
  localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam logic [RECIP_SHIFT-1:0] RECIP   = RECIP_SHIFT'((1 << RECIP_SHIFT) / SLOTS);
  localparam logic [SLOT_W:0]        SLOTS_C = (SLOT_W + 1)'(SLOTS);
  localparam logic [REM_W-1:0]       SLOTS_R = REM_W'(SLOTS);

  // item registers
  logic [REQ_W-1:0]  req_r;
  logic [ID_W-1:0]   id_r;
  logic [WORD_W-1:0] word_r;
  logic              force_r;

  // slot = id mod SLOTS by reciprocal multiply and one correction
  logic [PROD_W-1:0]       prod_r;
  logic [REM_W-1:0]        rem_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [ID_W-1:0]         quot;
  logic [ID_W+SLOT_W:0]    qs;
  logic [ID_W:0]           diff;

  logic [SLOTS-1:0]  dirty_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SLOT_W-1:0] idx_r;
  logic [THR_W-1:0]  thr_r;

  logic [SLOT_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [ID_W-1:0]       out_miss_r;
  logic [WORD_W-1:0]     out_data_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic                  out_last_r;

  logic [SLOT_OUT_W-1:0] slot_nxt;
  logic [ID_W-1:0]       miss_nxt;
  logic [WORD_W-1:0]     data_nxt;
  logic [LEVEL_W-1:0]    level_nxt;
  logic [CNT_W-1:0]      cnt_dec;

  assign quot    = prod_r[PROD_W-1:RECIP_SHIFT];
  assign qs      = quot * SLOTS_C;
  assign diff    = {1'b0, id_r} - (ID_W + 1)'(qs);
  assign cnt_dec = cnt_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_r   <= in_req_type;
      id_r    <= in_rec_id;
      word_r  <= in_record_word;
      force_r <= in_force_write;
    end
    if (cmd.step_mul) begin
      prod_r <= PROD_W'(id_r * RECIP);
    end
    if (cmd.step_mod) begin
      rem_r <= REM_W'(diff);
    end
    if (cmd.step_fix) begin
      slot_r <= SLOT_W'((rem_r >= SLOTS_R) ? rem_r - SLOTS_R : rem_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      thr_r   <= THR_RESET;
    end else begin
      if (thr_we) begin
        thr_r <= thr_wdata;
      end
      if (cmd.do_save) begin
        dirty_r[slot_r] <= 1'b1;
        if (!dirty_r[slot_r]) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else if (cmd.emit && cmd.emit_kind == KIND_FLASH_WRITE) begin
        dirty_r[idx_r] <= 1'b0;
        cnt_r          <= cnt_dec;
      end
      if (cmd.idx_clear) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
    end
  end

  assign raddr = cmd.rd_idx ? idx_r : slot_r;

  wcb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.do_save),
    .waddr (slot_r),
    .wdata (word_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    slot_nxt  = '0;
    miss_nxt  = '0;
    data_nxt  = '0;
    level_nxt = LEVEL_W'(cnt_r);
    case (cmd.emit_kind)
      KIND_SAVE_ACK: begin
        slot_nxt = SLOT_OUT_W'(slot_r);
      end
      KIND_LOAD_HIT: begin
        slot_nxt = SLOT_OUT_W'(slot_r);
        data_nxt = rdata;
      end
      KIND_LOAD_MISS: begin
        slot_nxt = SLOT_OUT_W'(slot_r);
        miss_nxt = id_r;
      end
      KIND_FLASH_WRITE: begin
        slot_nxt  = SLOT_OUT_W'(idx_r);
        data_nxt  = rdata;
        level_nxt = LEVEL_W'(cnt_dec);
      end
      default: begin
        level_nxt = '0;
      end
    endcase
  end

  // result register: a new word loads when the old one is gone or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= cmd.emit_kind;
      out_slot_r  <= slot_nxt;
      out_miss_r  <= miss_nxt;
      out_data_r  <= data_nxt;
      out_level_r <= level_nxt;
      out_last_r  <= cmd.emit_last;
    end
  end

  assign sts.req        = wcb_req_t'(req_r);
  assign sts.force_wr   = force_r;
  assign sts.slot_dirty = dirty_r[slot_r];
  assign sts.idx_dirty  = dirty_r[idx_r];
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cnt_one    = (cnt_r == CNT_W'(1));
  assign sts.thr_hit    = (CMP_W'(cnt_r) >= CMP_W'(thr_r));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign thr_value       = thr_r;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_slot_index  = out_slot_r;
  assign out_miss_id     = out_miss_r;
  assign out_data_word   = out_data_r;
  assign out_dirty_level = out_level_r;
  assign out_last_result = out_last_r;

`ifndef ASSERT_OFF
  a_cnt_matches_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(dirty_r)))
    else $error("dirty count out of step with dirty marks");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("dirty count above slot count");

  a_save_marks_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_save |=> dirty_r[$past(slot_r)])
    else $error("save did not mark its slot dirty");

  a_flash_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.emit_kind == KIND_FLASH_WRITE |=> !dirty_r[$past(idx_r)])
    else $error("flash write left its slot dirty");

  a_flash_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.emit_kind == KIND_FLASH_WRITE |=> out_last_r == (cnt_r == '0))
    else $error("last flag on flash write disagrees with dirty count");
`endif

endmodule

// ===== design/write_coalescing_buffer.sv =====
// top level of the direct-mapped write coalescing buffer
//
//   port      dir   handshake             contents
//   in_ch     in    valid/ready           req_type, rec_id, record_word, force_write
//   out_ch    out   valid/ready           result_kind, slot_index, miss_id, data_word,
//                                         dirty_level, last_result
//   apb       in    psel/penable/pready   flush_threshold at byte address 0
//
// a save or load first maps the record id to a slot (reciprocal multiply, subtract,
// correct), then works the slot ram, then loads the result register
// a flush walks the slots in order through the single ram read port, stopping at each
// dirty slot to write it out, until the last dirty slot is written out
// synchronous active-low reset clears the dirty marks and count, sets the threshold to 4;
// the slot ram is not cleared, a word is only passed out while its slot is dirty
// a new request is taken once the previous one has placed its last word in the result
// register; a stalled result register holds the sequencer at the next result
module write_coalescing_buffer import wcb_pkg::*; #(
  parameter int SLOTS = WCB_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  wcb_req_if.sink           in_ch,
  wcb_rsp_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  wcb_cmd_t         cmd;
  wcb_sts_t         sts;
  logic             in_ready;
  logic             thr_we;
  logic [THR_W-1:0] thr_value;

  assign pready = 1'b1;
  assign thr_we = psel && penable && pwrite && (paddr == ADDR_FLUSH_THR);
  assign prdata = (paddr == ADDR_FLUSH_THR) ? CFG_DW'(thr_value) : '0;

  assign in_ch.ready = in_ready;

  wcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wcb_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_rec_id       (in_ch.rec_id),
    .in_record_word  (in_ch.record_word),
    .in_force_write  (in_ch.force_write),
    .thr_we          (thr_we),
    .thr_wdata       (pwdata[THR_W-1:0]),
    .thr_value       (thr_value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_kind (out_ch.result_kind),
    .out_slot_index  (out_ch.slot_index),
    .out_miss_id     (out_ch.miss_id),
    .out_data_word   (out_ch.data_word),
    .out_dirty_level (out_ch.dirty_level),
    .out_last_result (out_ch.last_result)
  );

endmodule

// ===== test/tb.sv =====
// testbench for the write coalescing buffer: a mirror of the slots predicts every result word
`timescale 1ns / 100ps

module tb;
  import wcb_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] word;
    logic              flush_now;
  } buffer_request_t;

  typedef struct {
    wcb_kind_t             kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [ID_W-1:0]       miss_id;
    logic [WORD_W-1:0]     word;
    logic [LEVEL_W-1:0]    level;
    logic                  last;
  } buffer_response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  wcb_req_if in_ch ();
  wcb_rsp_if out_ch ();

  write_coalescing_buffer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the buffer contents
  logic [WORD_W-1:0] mirror_words [WCB_SLOTS];
  logic              mirror_dirty [WCB_SLOTS] = '{default: 1'b0};
  int unsigned       mirror_count = 0;
  logic [THR_W-1:0]  mirror_thr;

  buffer_request_t  request_backlog[$];
  buffer_response_t due_responses[$];
  logic [ID_W-1:0]  recent_ids[$];
  int               mismatch_count = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               stall_tick = 0;
  int               quiet_cycles = 0;

  function automatic void log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic string describe(logic [KIND_W-1:0] kind, logic [SLOT_OUT_W-1:0] slot,
                                     logic [ID_W-1:0] id, logic [WORD_W-1:0] word,
                                     logic [LEVEL_W-1:0] level, logic last);
    return $sformatf("kind %0d slot %0d id %h word %h level %0d last %b",
                     kind, slot, id, word, level, last);
  endfunction

  function automatic void post_result(wcb_kind_t kind, int slot, logic [ID_W-1:0] id,
                                      logic [WORD_W-1:0] word, int unsigned level);
    buffer_response_t r;
    r.kind    = kind;
    r.slot    = SLOT_OUT_W'(slot);
    r.miss_id = id;
    r.word    = word;
    r.level   = LEVEL_W'(level);
    r.last    = 1'b0;
    due_responses.push_back(r);
  endfunction

  // one flash write per dirty slot, lowest slot first
  function automatic void drain_dirty_slots();
    for (int i = 0; i < WCB_SLOTS; i++) begin
      if (mirror_dirty[i]) begin
        mirror_dirty[i] = 1'b0;
        if (mirror_count > 0) mirror_count--;
        post_result(KIND_FLASH_WRITE, i, '0, mirror_words[i], mirror_count);
      end
    end
    mirror_count = 0;
  endfunction

  function automatic void coalesce_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                           logic [WORD_W-1:0] word, logic flush_now);
    int slot;
    int first;
    first = due_responses.size();
    slot = id % WCB_SLOTS;
    case (req)
      REQ_SAVE: begin
        mirror_words[slot] = word;
        if (!mirror_dirty[slot]) begin
          mirror_dirty[slot] = 1'b1;
          mirror_count++;
        end
        post_result(KIND_SAVE_ACK, slot, '0, '0, mirror_count);
        if (flush_now || mirror_count >= mirror_thr) drain_dirty_slots();
      end
      REQ_LOAD: begin
        if (mirror_dirty[slot]) post_result(KIND_LOAD_HIT, slot, '0, mirror_words[slot],
                                            mirror_count);
        else post_result(KIND_LOAD_MISS, slot, id, '0, mirror_count);
      end
      REQ_FLUSH: begin
        if (mirror_count == 0) post_result(KIND_FLUSH_EMPTY, 0, '0, '0, 0);
        else drain_dirty_slots();
      end
      default: begin
        // unused request code leaves everything untouched
      end
    endcase
    if (due_responses.size() > first) due_responses[due_responses.size()-1].last = 1'b1;
  endfunction

  function automatic void queue_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                        logic [WORD_W-1:0] word, logic flush_now);
    buffer_request_t r;
    r.req       = req;
    r.id        = id;
    r.word      = word;
    r.flush_now = flush_now;
    request_backlog.push_back(r);
  endfunction

  // saves to all slots in order, upper id bits random
  function automatic void queue_slot_sweep(logic force_last);
    for (int s = 0; s < WCB_SLOTS; s++)
      queue_request(REQ_SAVE, ID_W'({12'($urandom_range(0, 4095)), 4'(s)}),
                    {$urandom, $urandom}, force_last && s == WCB_SLOTS - 1);
  endfunction

  function automatic void queue_random_traffic(int count);
    int made;
    int pick;
    logic [ID_W-1:0] id;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      id = ID_W'($urandom);
      if (recent_ids.size() != 0 && $urandom_range(0, 9) < 4)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      if (pick < 52) begin
        queue_request(REQ_SAVE, id, {$urandom, $urandom}, $urandom_range(0, 9) == 0);
        recent_ids.push_back(id);
        if (recent_ids.size() > 8) void'(recent_ids.pop_front());
        made++;
      end else if (pick < 82) begin
        // loads lean on recently saved ids so that hits show up
        if (recent_ids.size() != 0 && $urandom_range(0, 9) < 6)
          id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        queue_request(REQ_LOAD, id, {$urandom, $urandom}, 1'($urandom));
        made++;
      end else if (pick < 95) begin
        queue_request(REQ_FLUSH, id, {$urandom, $urandom}, 1'($urandom));
        made++;
      end else begin
        queue_request(REQ_UNUSED, id, {$urandom, $urandom}, 1'($urandom));
      end
    end
  endfunction

  task automatic write_threshold(logic [THR_W-1:0] value);
    logic [CFG_DW-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FLUSH_THR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mirror_thr = value;
    // read back straight after, psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[THR_W-1:0] !== value)
      log_mismatch($sformatf("threshold reads %0d, want %0d", readback[THR_W-1:0], value));
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_ch.valid || due_responses.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : request_driver
    buffer_request_t next_req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        coalesce_request(in_ch.req_type, in_ch.rec_id, in_ch.record_word,
                         in_ch.force_write);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          next_req = request_backlog.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= next_req.req;
          in_ch.rec_id      <= next_req.id;
          in_ch.record_word <= next_req.word;
          in_ch.force_write <= next_req.flush_now;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, ready pattern steps through four modes in turn
  always @(posedge clk) begin : result_monitor
    buffer_response_t want;
    string got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = describe(out_ch.result_kind, out_ch.slot_index, out_ch.miss_id,
                       out_ch.data_word, out_ch.dirty_level, out_ch.last_result);
        if (due_responses.size() == 0) begin
          log_mismatch({"unexpected result word: ", got});
        end else begin
          want = due_responses.pop_front();
          if (out_ch.result_kind !== want.kind || out_ch.slot_index !== want.slot ||
              out_ch.miss_id !== want.miss_id || out_ch.data_word !== want.word ||
              out_ch.dirty_level !== want.level || out_ch.last_result !== want.last)
            log_mismatch({"got ", got, ", want ",
                          describe(want.kind, want.slot, want.miss_id, want.word,
                                   want.level, want.last)});
        end
      end
      stall_tick++;
      case (stall_tick[8:7])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ch.ready <= stall_tick[3];
        default: out_ch.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("write_coalescing_buffer verification failed");
        $finish;
      end
    end
  end

  initial begin
    mirror_thr = THR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset threshold
    queue_request(REQ_FLUSH, '0, '0, 1'b0);
    queue_request(REQ_LOAD, 16'hFFFF, '0, 1'b0);
    queue_request(REQ_SAVE, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_request(REQ_LOAD, 16'h0010, '0, 1'b0);
    queue_request(REQ_SAVE, 16'hFFFF, 64'h0, 1'b0);
    queue_request(REQ_SAVE, 16'h0010, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
    queue_request(REQ_LOAD, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_request(REQ_UNUSED, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_request(REQ_SAVE, 16'h0003, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1);
    queue_request(REQ_LOAD, 16'h0003, '0, 1'b0);
    queue_request(REQ_SAVE, 16'h0001, 64'h1, 1'b0);
    queue_request(REQ_SAVE, 16'h0002, 64'h2, 1'b0);
    queue_request(REQ_SAVE, 16'h0004, 64'h4, 1'b0);
    queue_request(REQ_SAVE, 16'h0008, 64'h8000_0000_0000_0000, 1'b0);
    queue_request(REQ_SAVE, 16'h8000, 64'h0123_4567_89AB_CDEF, 1'b0);
    queue_request(REQ_LOAD, 16'h8000, '0, 1'b0);
    queue_request(REQ_FLUSH, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_request(REQ_FLUSH, '0, '0, 1'b0);
    queue_request(REQ_LOAD, 16'h8000, '0, 1'b0);
    wait_until_drained();

    // zero threshold: every save flushes
    write_threshold(5'd0);
    queue_random_traffic(30);
    wait_until_drained();

    // threshold out of reach: saves fill all slots, the last save forced
    write_threshold(5'd17);
    queue_slot_sweep(1'b1);
    queue_random_traffic(30);
    wait_until_drained();

    write_threshold(5'd1);
    queue_random_traffic(30);
    wait_until_drained();

    write_threshold(5'd16);
    queue_slot_sweep(1'b0);
    queue_random_traffic(30);
    wait_until_drained();

    write_threshold(5'd31);
    queue_slot_sweep(1'b0);
    queue_request(REQ_FLUSH, '0, '0, 1'b0);
    queue_random_traffic(30);
    wait_until_drained();

    write_threshold(THR_W'($urandom_range(2, 15)));
    queue_random_traffic(30);
    wait_until_drained();

    write_threshold(THR_W'($urandom_range(2, 15)));
    queue_random_traffic(30);
    wait_until_drained();

    if (mismatch_count == 0 && due_responses.size() == 0) begin
      $display("write_coalescing_buffer verification clean");
    end else begin
      $display("write_coalescing_buffer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/wcb_pkg.sv
design/wcb_intf.sv
design/wcb_ram.sv
design/wcb_ctrl.sv
design/wcb_datapath.sv
design/write_coalescing_buffer.sv
test/tb.sv
